/* rtl/core/tdf_pkg.sv */
// tdf_pkg: shared types, constants and saturation helpers for the tracking differentiator
`timescale 1ns / 1ps

package tdf_pkg;

    // word widths fixed by the payload fields
    localparam int DW        = 32;
    localparam int IW        = DW + 8;
    localparam int XW        = IW + 4;
    localparam int PW        = 2 * IW;
    localparam int RW        = IW + 2;
    localparam int MUL_DIGIT = 8;
    localparam int MUL_STEPS = (IW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int MB_W      = MUL_STEPS * MUL_DIGIT;
    localparam int CNT_W     = $clog2(IW);
    localparam int SPEED_W   = 31;
    localparam int STEP_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd1;
    localparam logic [SPEED_W-1:0]   SPEED_RESET = 31'd6553600;
    localparam logic [STEP_W-1:0]    STEP_RESET  = 17'd655;

    // input operation codes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef logic signed [XW-1:0] xw_t;

    localparam xw_t IW_HI = xw_t'((XW'(1) << (IW - 1)) - XW'(1));
    localparam xw_t IW_LO = -IW_HI - xw_t'(1);
    localparam xw_t DW_HI = xw_t'((XW'(1) << (DW - 1)) - XW'(1));
    localparam xw_t DW_LO = -DW_HI - xw_t'(1);
    localparam logic [IW-1:0] IW_MAX = {1'b0, {(IW - 1){1'b1}}};

    typedef struct packed {
        logic                 op;
        logic signed [DW-1:0] target;
    } in_word_t;

    typedef struct packed {
        logic signed [DW-1:0] tracked_out;
        logic signed [DW-1:0] derivative_out;
        logic signed [DW-1:0] accel_out;
        logic                 saturated;
    } out_word_t;

    // datapath jobs, run in this order for an update
    typedef enum logic [3:0] {
        JOB_RH, JOB_D, JOB_A0, JOB_Y, JOB_T, JOB_DT,
        JOB_SQRT, JOB_SEL, JOB_DIV, JOB_RQ, JOB_HF
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_START, ST_RUN, ST_DONE
    } state_t;

    typedef struct packed {
        logic accept_update;
        logic accept_clear;
        logic start;
        job_t job;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic busy;
    } dp_stat_t;

    function automatic logic [IW-1:0] mag_iw(input logic signed [IW-1:0] v);
        return v[IW-1] ? unsigned'(-v) : unsigned'(v);
    endfunction

    function automatic logic ovf_iw(input xw_t v);
        return (v > IW_HI) || (v < IW_LO);
    endfunction

    function automatic logic signed [IW-1:0] sat_iw(input xw_t v);
        logic signed [IW-1:0] r;
        if (v > IW_HI)
            r = IW_HI[IW-1:0];
        else if (v < IW_LO)
            r = IW_LO[IW-1:0];
        else
            r = v[IW-1:0];
        return r;
    endfunction

    function automatic logic ovf_dw(input xw_t v);
        return (v > DW_HI) || (v < DW_LO);
    endfunction

    function automatic logic signed [DW-1:0] sat_dw(input xw_t v);
        logic signed [DW-1:0] r;
        if (v > DW_HI)
            r = DW_HI[DW-1:0];
        else if (v < DW_LO)
            r = DW_LO[DW-1:0];
        else
            r = v[DW-1:0];
        return r;
    endfunction

endpackage

/* rtl/core/tdf_ctrl.sv */
// tdf_ctrl: sequencer that walks the datapath through the jobs of one word
`timescale 1ns / 1ps

module tdf_ctrl import tdf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     op,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg, state_next;
    job_t   job_reg, job_next;
    logic   out_valid_reg, out_valid_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_RH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    job_next   = JOB_RH;
                    state_next = (op == OP_CLEAR) ? ST_DONE : ST_START;
                end
            end
            ST_START:
                state_next = ST_RUN;
            ST_RUN:
            begin
                if (stat.done)
                begin
                    if (job_reg == JOB_HF)
                        state_next = ST_DONE;
                    else
                    begin
                        job_next   = job_t'(job_reg + 4'd1);
                        state_next = ST_START;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and commands
    always_comb
    begin
        in_ready          = (state_reg == ST_IDLE);
        cmd.accept_update = (state_reg == ST_IDLE) && in_valid && (op == OP_UPDATE);
        cmd.accept_clear  = (state_reg == ST_IDLE) && in_valid && (op == OP_CLEAR);
        cmd.start         = (state_reg == ST_START);
        cmd.job           = job_reg;
        cmd.load_out      = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/tdf_dp.sv */
// tdf_dp: fixed-point datapath with shared multiplier, square root and divider
`timescale 1ns / 1ps

module tdf_dp import tdf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic signed [DW-1:0] target,
    input  logic [SPEED_W-1:0]   speed,
    input  logic [STEP_W-1:0]    step,
    output out_word_t            out_word
);

    localparam int QW  = FRAC_BITS + 2;
    localparam int DRW = IW + 1;

    // control and tracked state
    logic                 busy_reg, fin_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic signed [DW-1:0] x1_reg, x2_reg, acc_reg;

    // payload registers
    logic signed [DW-1:0] v_reg, fh_reg;
    logic signed [IW-1:0] d_reg, a0_reg, y_reg, t_reg, a_reg;
    logic [IW-1:0]        a1_reg;
    logic signed [QW-1:0] q_reg;
    logic                 clip_reg;
    logic [IW-1:0]        ma_reg;
    logic [MB_W-1:0]      mb_reg;
    logic [PW-1:0]        prod_reg;
    logic                 neg_reg;
    logic [PW-1:0]        rad_reg;
    logic [IW-1:0]        root_reg;
    logic [RW-1:0]        rem_reg;
    logic [DRW-1:0]       drem_reg;
    logic [QW-1:0]        quo_reg;
    out_word_t            out_reg;

    logic signed [IW-1:0] r_s, h_s, x2_s, fh_s, q_s, opa, opb;
    logic [CNT_W-1:0]     last;

    assign r_s  = signed'(IW'(speed));
    assign h_s  = signed'(IW'(step));
    assign x2_s = IW'(x2_reg);
    assign fh_s = IW'(fh_reg);
    assign q_s  = IW'(q_reg);

    // operand select and step count per job
    always_comb
    begin
        opa  = '0;
        opb  = '0;
        last = '0;
        unique case (cmd.job)
            JOB_RH:   begin opa = r_s;   opb = h_s;  last = CNT_W'(MUL_STEPS - 1); end
            JOB_D:    begin opa = d_reg; opb = h_s;  last = CNT_W'(MUL_STEPS - 1); end
            JOB_A0:   begin opa = h_s;   opb = x2_s; last = CNT_W'(MUL_STEPS - 1); end
            JOB_DT:   begin opa = d_reg; opb = t_reg; last = CNT_W'(MUL_STEPS - 1); end
            JOB_RQ:   begin opa = r_s;   opb = q_s;  last = CNT_W'(MUL_STEPS - 1); end
            JOB_HF:   begin opa = h_s;   opb = fh_s; last = CNT_W'(MUL_STEPS - 1); end
            JOB_SQRT: last = CNT_W'(IW - 1);
            JOB_DIV:  last = CNT_W'(FRAC_BITS);
            default:  last = '0;
        endcase
    end

    // multiplier digit step
    logic [IW+MUL_DIGIT-1:0] pp;
    logic [PW-1:0]           prod_step;
    assign pp        = ma_reg * mb_reg[MB_W-1 -: MUL_DIGIT];
    assign prod_step = (prod_reg << MUL_DIGIT) + PW'(pp);

    // fixed-point product rescale and saturation
    logic [PW-1:0]        fm_sh;
    logic                 fm_sat;
    logic [IW-1:0]        fm_mag;
    logic signed [IW-1:0] fm_val;
    assign fm_sh  = prod_reg >> FRAC_BITS;
    assign fm_sat = fm_sh > PW'(IW_MAX);
    assign fm_mag = fm_sat ? IW_MAX : fm_sh[IW-1:0];
    assign fm_val = neg_reg ? -signed'(fm_mag) : signed'(fm_mag);

    // square root digit step
    logic [RW+1:0] rem2, trial;
    logic          sq_ge;
    assign rem2  = {rem_reg, rad_reg[PW-1 -: 2]};
    assign trial = (RW + 2)'({root_reg, 2'b01});
    assign sq_ge = rem2 >= trial;

    // divider digit step
    logic [DRW-1:0] drs;
    logic           dv_ge;
    assign drs   = (cnt_reg == '0) ? drem_reg : (drem_reg << 1);
    assign dv_ge = drs >= DRW'(unsigned'(d_reg));

    // error, y and t terms
    xw_t e_x, ysum_x, m8_x, tsum_x;
    logic signed [IW-1:0] c8;
    assign e_x    = xw_t'(x1_reg) - xw_t'(v_reg);
    assign ysum_x = e_x + xw_t'(a0_reg);
    assign m8_x   = xw_t'({mag_iw(y_reg), 3'b000});
    assign c8     = sat_iw(m8_x);
    assign tsum_x = xw_t'(d_reg) + xw_t'(c8);

    // a2, linear-zone a and fhan selection terms
    xw_t diff_x, half_x, a2_x, aalt_x, fhs_x, x1s_x, x2s_x;
    logic lin_y, lin_a;
    assign diff_x = xw_t'(a1_reg) - xw_t'(d_reg);
    assign half_x = diff_x >>> 1;
    assign a2_x   = y_reg[IW-1] ? (xw_t'(a0_reg) - half_x) : (xw_t'(a0_reg) + half_x);
    assign aalt_x = xw_t'(a0_reg) + xw_t'(y_reg);
    assign lin_y  = (xw_t'(y_reg) >= -xw_t'(d_reg)) && (xw_t'(y_reg) < xw_t'(d_reg));
    assign lin_a  = (xw_t'(a_reg) >= -xw_t'(d_reg)) && (xw_t'(a_reg) < xw_t'(d_reg));
    assign fhs_x  = lin_a ? -xw_t'(fm_val)
                          : (a_reg[IW-1] ? xw_t'(r_s) : -xw_t'(r_s));
    assign x1s_x  = xw_t'(x1_reg) + xw_t'(a0_reg);
    assign x2s_x  = xw_t'(x2_reg) + xw_t'(fm_val);

    // sequencing and tracked state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
            x1_reg   <= '0;
            x2_reg   <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            fin_reg <= busy_reg && !cmd.start && (cnt_reg == last);
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == last)
                    busy_reg <= 1'b0;
            end
            if (cmd.accept_clear)
            begin
                x1_reg  <= '0;
                x2_reg  <= '0;
                acc_reg <= '0;
            end
            else if (fin_reg && (cmd.job == JOB_HF))
            begin
                x1_reg  <= sat_dw(x1s_x);
                x2_reg  <= sat_dw(x2s_x);
                acc_reg <= fh_reg;
            end
        end
    end

    // working registers: loads, digit steps and job results
    always_ff @(posedge clk)
    begin
        if (cmd.accept_update)
        begin
            v_reg    <= target;
            clip_reg <= 1'b0;
        end
        if (cmd.accept_clear)
            clip_reg <= 1'b0;

        if (cmd.start)
        begin
            unique case (cmd.job)
                JOB_SQRT:
                begin
                    rad_reg  <= prod_reg;
                    root_reg <= '0;
                    rem_reg  <= '0;
                end
                JOB_DIV:
                begin
                    drem_reg <= DRW'(mag_iw(a_reg));
                    quo_reg  <= '0;
                end
                default:
                begin
                    ma_reg   <= mag_iw(opa);
                    mb_reg   <= MB_W'(mag_iw(opb));
                    neg_reg  <= opa[IW-1] ^ opb[IW-1];
                    prod_reg <= '0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            unique case (cmd.job)
                JOB_RH, JOB_D, JOB_A0, JOB_DT, JOB_RQ, JOB_HF:
                begin
                    prod_reg <= prod_step;
                    mb_reg   <= mb_reg << MUL_DIGIT;
                end
                JOB_SQRT:
                begin
                    rem_reg  <= RW'(sq_ge ? (rem2 - trial) : rem2);
                    root_reg <= {root_reg[IW-2:0], sq_ge};
                    rad_reg  <= rad_reg << 2;
                end
                JOB_DIV:
                begin
                    drem_reg <= dv_ge ? (drs - DRW'(unsigned'(d_reg))) : drs;
                    quo_reg  <= {quo_reg[QW-2:0], dv_ge};
                end
                default: ;
            endcase
        end

        if (fin_reg)
        begin
            unique case (cmd.job)
                JOB_RH:
                begin
                    d_reg    <= fm_val;
                    clip_reg <= clip_reg | fm_sat;
                end
                JOB_D:
                begin
                    d_reg    <= (fm_val[IW-1] || (fm_val == '0)) ? IW'(1) : fm_val;
                    clip_reg <= clip_reg | fm_sat;
                end
                JOB_A0:
                begin
                    a0_reg   <= fm_val;
                    clip_reg <= clip_reg | fm_sat;
                end
                JOB_Y:
                begin
                    y_reg    <= sat_iw(ysum_x);
                    clip_reg <= clip_reg | ovf_iw(ysum_x);
                end
                JOB_T:
                begin
                    t_reg    <= sat_iw(tsum_x);
                    clip_reg <= clip_reg | ovf_iw(m8_x) | ovf_iw(tsum_x);
                end
                JOB_SQRT:
                    a1_reg <= root_reg;
                JOB_SEL:
                begin
                    a_reg    <= lin_y ? sat_iw(aalt_x) : sat_iw(a2_x);
                    clip_reg <= clip_reg | ovf_iw(a2_x) | (lin_y & ovf_iw(aalt_x));
                end
                JOB_DIV:
                    q_reg <= a_reg[IW-1] ? -signed'(quo_reg) : signed'(quo_reg);
                JOB_RQ:
                begin
                    fh_reg   <= sat_dw(fhs_x);
                    clip_reg <= clip_reg | (lin_a & fm_sat) | ovf_dw(fhs_x);
                end
                JOB_HF:
                    clip_reg <= clip_reg | fm_sat | ovf_dw(x1s_x) | ovf_dw(x2s_x);
                default: ;
            endcase
        end

        if (cmd.load_out)
        begin
            out_reg.tracked_out    <= x1_reg;
            out_reg.derivative_out <= x2_reg;
            out_reg.accel_out      <= acc_reg;
            out_reg.saturated      <= clip_reg;
        end
    end

    assign stat.done = fin_reg;
    assign stat.busy = busy_reg;
    assign out_word  = out_reg;

endmodule

/* rtl/core/tracking_differentiator_fhan_top.sv */
// tracking_differentiator_fhan_top: fhan tracking differentiator with config registers
//
// Input channel (in_valid/in_ready/in_data) takes one word: op and a signed
// Q16.16 target. An update word advances tracked value and derivative with
// fhan of the tracking error; a clear word zeroes all three state values.
// Output channel (out_valid/out_ready/out_data) gives one word per input:
// tracked value, derivative, fhan result and a saturation flag.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes speed
// factor (index 0) and step size (index 1); other indexes are ignored.
// An update runs through the 40-step bitwise square root, six multiplies
// through a 40x8 multiplier at five digits each, and the 17-step restoring
// divide. A clear goes straight to the done state and loads the output
// register once it is free. One word is in work at a time; the next is
// taken once the current result sits in the output register.
// Reset: state values clear to zero, speed factor 100.0, step about 0.01.
// When the receiver stalls the result holds in the output register and the
// next word is still accepted and worked on, finishing into the register
// once it is freed.
`timescale 1ns / 1ps

module tracking_differentiator_fhan_top import tdf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [SPEED_W-1:0] speed_reg;
    logic [STEP_W-1:0]  step_reg;
    dp_cmd_t            cmd;
    dp_stat_t           stat;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= SPEED_RESET;
            step_reg  <= STEP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SPEED: speed_reg <= cfg_data[SPEED_W-1:0];
                CFG_STEP:  step_reg  <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    tdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (in_data.op),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // arithmetic
    tdf_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .target   (in_data.target),
        .speed    (speed_reg),
        .step     (step_reg),
        .out_word (out_data)
    );

    // an accepted word keeps the input closed for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a word is in work");

    // a clear with a free output register reports through the done state into the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.op && !out_valid |=> ##1 out_valid)
        else $error("clear result late");

    // that clear result is all zero and unclipped
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.op && !out_valid |=> ##1
        (out_data.tracked_out == '0 && out_data.derivative_out == '0 &&
         out_data.accel_out == '0 && !out_data.saturated))
        else $error("clear result not zero");

endmodule
